// ===== rtl/crdt_pkg.sv =====
// Package for the three-channel reload down timer: payload structs, register map,
// control bit positions and small decode helpers.
// No dependencies; used by crdt_channel and three_channel_reload_down_timer.
package crdt_pkg;

    localparam int MAX_CHANNELS = 3;
    localparam int CLK_SEL_W    = 3;
    localparam int PRESC_W      = 10;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register map
    localparam logic [3:0] REG_OUT_CTRL = 4'd0;
    localparam logic [3:0] REG_START    = 4'd1;
    localparam logic [3:0] REG_CONST0   = 4'd2;
    localparam logic [3:0] REG_COUNT0   = 4'd3;
    localparam logic [3:0] REG_CTRL0    = 4'd4;
    localparam logic [3:0] REG_CONST1   = 4'd5;
    localparam logic [3:0] REG_COUNT1   = 4'd6;
    localparam logic [3:0] REG_CTRL1    = 4'd7;
    localparam logic [3:0] REG_CONST2   = 4'd8;
    localparam logic [3:0] REG_COUNT2   = 4'd9;
    localparam logic [3:0] REG_CTRL2    = 4'd10;
    localparam logic [3:0] REG_CAPTURE  = 4'd11;

    // Decoded register classes
    localparam logic [2:0] SEL_NONE    = 3'd0;
    localparam logic [2:0] SEL_OUT_CTRL = 3'd1;
    localparam logic [2:0] SEL_START   = 3'd2;
    localparam logic [2:0] SEL_CONST   = 3'd3;
    localparam logic [2:0] SEL_COUNT   = 3'd4;
    localparam logic [2:0] SEL_CTRL    = 3'd5;
    localparam logic [2:0] SEL_CAPTURE = 3'd6;

    // Control register bits
    localparam logic [15:0] FLAG_UNDERFLOW  = 16'h0100;
    localparam logic [15:0] FLAG_IRQ_ENABLE = 16'h0020;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
    } crdt_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  irq_lines;
    } crdt_out_t;

    typedef struct packed {
        logic [2:0] sel;
        logic [1:0] ch;
    } crdt_reg_sel_t;

    // Per-channel update request for one processed item
    typedef struct packed {
        logic        tick;
        logic        wr_const;
        logic        wr_count;
        logic        wr_ctrl;
        logic        clr_presc;
        logic [31:0] wdata;
        logic [31:0] wmask;
    } crdt_chan_op_t;

    function automatic crdt_reg_sel_t reg_decode(input logic [3:0] idx);
        crdt_reg_sel_t r;
        r.sel = SEL_NONE;
        r.ch  = 2'd0;
        unique case (idx)
            REG_OUT_CTRL: r.sel = SEL_OUT_CTRL;
            REG_START:    r.sel = SEL_START;
            REG_CONST0:   begin r.sel = SEL_CONST; r.ch = 2'd0; end
            REG_COUNT0:   begin r.sel = SEL_COUNT; r.ch = 2'd0; end
            REG_CTRL0:    begin r.sel = SEL_CTRL;  r.ch = 2'd0; end
            REG_CONST1:   begin r.sel = SEL_CONST; r.ch = 2'd1; end
            REG_COUNT1:   begin r.sel = SEL_COUNT; r.ch = 2'd1; end
            REG_CTRL1:    begin r.sel = SEL_CTRL;  r.ch = 2'd1; end
            REG_CONST2:   begin r.sel = SEL_CONST; r.ch = 2'd2; end
            REG_COUNT2:   begin r.sel = SEL_COUNT; r.ch = 2'd2; end
            REG_CTRL2:    begin r.sel = SEL_CTRL;  r.ch = 2'd2; end
            REG_CAPTURE:  r.sel = SEL_CAPTURE;
            default:      r.sel = SEL_NONE;
        endcase
        return r;
    endfunction

    // Ticks per count step for each clock select code
    function automatic logic [PRESC_W:0] tick_divisor(input logic [CLK_SEL_W-1:0] code);
        logic [PRESC_W:0] d;
        unique case (code)
            3'd0:    d = 11'd4;
            3'd1:    d = 11'd16;
            3'd2:    d = 11'd64;
            3'd3:    d = 11'd256;
            3'd4:    d = 11'd1024;
            default: d = 11'd1;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] lane_mask(input logic [3:0] be);
        logic [31:0] m;
        for (int lane = 0; lane < 4; lane++) begin
            m[lane*8 +: 8] = {8{be[lane]}};
        end
        return m;
    endfunction

    function automatic logic [31:0] merge_bytes(input logic [31:0] old,
                                                input logic [31:0] data,
                                                input logic [31:0] mask);
        return (old & ~mask) | (data & mask);
    endfunction

endpackage

// ===== rtl/crdt_channel.sv =====
// One timer channel: prescaler, down counter, reload constant, control and irq.
// Depends on crdt_pkg for the operation struct, control bits and helpers.
module crdt_channel (
    input  logic                  clk,
    input  logic                  rst_n,
    input  crdt_pkg::crdt_chan_op_t op,
    output logic [31:0]           count,
    output logic [31:0]           reload,
    output logic [15:0]           control,
    output logic                  irq_next
);

    logic [31:0]                 count_reg,  count_next;
    logic [31:0]                 reload_reg, reload_next;
    logic [15:0]                 ctrl_reg,   ctrl_next;
    logic [crdt_pkg::PRESC_W-1:0] presc_reg,  presc_next;
    logic                        irq_reg;
    logic [crdt_pkg::PRESC_W:0]  presc_inc;

    assign presc_inc = {1'b0, presc_reg} + 1'b1;

    // Advance on ticks, merge bus writes
    always_comb
    begin
        count_next  = count_reg;
        reload_next = reload_reg;
        ctrl_next   = ctrl_reg;
        presc_next  = presc_reg;
        irq_next    = irq_reg;
        if (op.tick)
        begin
            if (presc_inc < crdt_pkg::tick_divisor(ctrl_reg[crdt_pkg::CLK_SEL_W-1:0]))
            begin
                presc_next = presc_inc[crdt_pkg::PRESC_W-1:0];
            end
            else
            begin
                presc_next = '0;
                if (count_reg == 32'd0)
                begin
                    // underflow: reload, flag, maybe request
                    count_next = reload_reg;
                    ctrl_next  = ctrl_reg | crdt_pkg::FLAG_UNDERFLOW;
                    if ((ctrl_reg & crdt_pkg::FLAG_IRQ_ENABLE) != 16'd0)
                    begin
                        irq_next = 1'b1;
                    end
                end
                else
                begin
                    count_next = count_reg - 32'd1;
                end
            end
        end
        if (op.wr_const)
        begin
            reload_next = crdt_pkg::merge_bytes(reload_reg, op.wdata, op.wmask);
            presc_next  = '0;
        end
        if (op.wr_count)
        begin
            count_next = crdt_pkg::merge_bytes(count_reg, op.wdata, op.wmask);
            presc_next = '0;
        end
        if (op.wr_ctrl)
        begin
            ctrl_next  = (ctrl_reg & ~op.wmask[15:0]) | (op.wdata[15:0] & op.wmask[15:0]);
            presc_next = '0;
            // drop the request if enable or flag is clear
            if ((ctrl_next & crdt_pkg::FLAG_IRQ_ENABLE) == 16'd0 ||
                (ctrl_next & crdt_pkg::FLAG_UNDERFLOW) == 16'd0)
            begin
                irq_next = 1'b0;
            end
        end
        if (op.clr_presc)
        begin
            presc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '1;
            reload_reg <= '1;
            ctrl_reg   <= '0;
            presc_reg  <= '0;
            irq_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            ctrl_reg   <= ctrl_next;
            presc_reg  <= presc_next;
            irq_reg    <= irq_next;
        end
    end

    assign count   = count_reg;
    assign reload  = reload_reg;
    assign control = ctrl_reg;

endmodule

// ===== rtl/three_channel_reload_down_timer.sv =====
// Top level of the three-channel reload down timer: input register, register file,
// channel instances and result register. Depends on crdt_pkg and crdt_channel.
//
// Usage:
//   The in channel carries one item per transfer: a peripheral clock tick, a
//   register read or a byte-masked register write (in_data, crdt_pkg::crdt_in_t).
//   The out channel returns exactly one result per item (out_data): the read
//   value (zero for ticks and writes) and the three interrupt request lines as
//   they stand after the item has taken effect.
//   Path: an accepted item is captured in the input register, processed from there,
//   and its result is written to the result register and offered on out_valid.
//   Throughput: one item per cycle while out_ready does not stall, set by the update
//   path from the input register through the channel logic into the result register.
//   Stall: when out_ready is low the result is held; one more item waits in the
//   input register, and only then does in_ready drop.
//   Reset (rst_n low, asynchronous): counts and constants go to all ones, control,
//   start, output control, capture, prescalers and requests to zero, and both
//   pipeline stages empty.
//   CHANNELS (1..3) sets how many channels exist; absent ones read as zero and
//   ignore writes.
module three_channel_reload_down_timer #(
    parameter int CHANNELS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  crdt_pkg::crdt_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output crdt_pkg::crdt_out_t  out_data
);

    logic                   in_vld_reg;
    crdt_pkg::crdt_in_t     in_reg;
    logic                   out_vld_reg;
    crdt_pkg::crdt_out_t    out_reg, out_next;
    logic [7:0]             start_reg,   start_next;
    logic [7:0]             outctl_reg,  outctl_next;
    logic [31:0]            capture_reg, capture_next;

    logic                   fire;
    logic                   is_write;
    logic                   is_tick;
    crdt_pkg::crdt_reg_sel_t sel;
    logic [31:0]            wmask;

    logic [31:0] ch_count   [crdt_pkg::MAX_CHANNELS];
    logic [31:0] ch_reload  [crdt_pkg::MAX_CHANNELS];
    logic [15:0] ch_control [crdt_pkg::MAX_CHANNELS];
    logic [2:0]  irq_vec;

    // Process the held item when the result slot is free or being drained
    assign fire     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || fire;

    assign sel      = crdt_pkg::reg_decode(in_reg.reg_index);
    assign is_write = fire && (in_reg.kind == crdt_pkg::KIND_WRITE);
    assign is_tick  = fire && (in_reg.kind == crdt_pkg::KIND_TICK);
    assign wmask    = crdt_pkg::lane_mask(in_reg.byte_enable);

    // Channel instances; absent channels tie off to zero
    for (genvar i = 0; i < crdt_pkg::MAX_CHANNELS; i++)
    begin : g_ch
        if (i < CHANNELS)
        begin : g_on
            crdt_pkg::crdt_chan_op_t op;
            logic                    irq_n;

            always_comb
            begin
                op.tick      = is_tick && start_reg[i];
                op.wr_const  = is_write && (sel.sel == crdt_pkg::SEL_CONST) &&
                               (sel.ch == 2'(i));
                op.wr_count  = is_write && (sel.sel == crdt_pkg::SEL_COUNT) &&
                               (sel.ch == 2'(i));
                op.wr_ctrl   = is_write && (sel.sel == crdt_pkg::SEL_CTRL) &&
                               (sel.ch == 2'(i));
                op.clr_presc = is_write && (sel.sel == crdt_pkg::SEL_START);
                op.wdata     = in_reg.write_data;
                op.wmask     = wmask;
            end

            crdt_channel u_ch (
                .clk      (clk),
                .rst_n    (rst_n),
                .op       (op),
                .count    (ch_count[i]),
                .reload   (ch_reload[i]),
                .control  (ch_control[i]),
                .irq_next (irq_n)
            );

            assign irq_vec[i] = irq_n;
        end
        else
        begin : g_off
            assign ch_count[i]   = '0;
            assign ch_reload[i]  = '0;
            assign ch_control[i] = '0;
            assign irq_vec[i]    = 1'b0;
        end
    end

    // Merge writes to the shared registers
    always_comb
    begin
        start_next   = start_reg;
        outctl_next  = outctl_reg;
        capture_next = capture_reg;
        if (is_write)
        begin
            unique case (sel.sel)
                crdt_pkg::SEL_OUT_CTRL:
                    outctl_next = (outctl_reg & ~wmask[7:0]) | (in_reg.write_data[7:0] & wmask[7:0]);
                crdt_pkg::SEL_START:
                    start_next = (start_reg & ~wmask[7:0]) | (in_reg.write_data[7:0] & wmask[7:0]);
                crdt_pkg::SEL_CAPTURE:
                    capture_next = crdt_pkg::merge_bytes(capture_reg, in_reg.write_data, wmask);
                default: ;
            endcase
        end
    end

    // Build the result: read value and the request lines after the update
    always_comb
    begin
        out_next.read_data = 32'd0;
        out_next.irq_lines = irq_vec;
        if (in_reg.kind == crdt_pkg::KIND_READ)
        begin
            unique case (sel.sel)
                crdt_pkg::SEL_OUT_CTRL: out_next.read_data = {24'd0, outctl_reg};
                crdt_pkg::SEL_START:    out_next.read_data = {24'd0, start_reg};
                crdt_pkg::SEL_CAPTURE:  out_next.read_data = capture_reg;
                crdt_pkg::SEL_CONST:    out_next.read_data = ch_reload[sel.ch];
                crdt_pkg::SEL_COUNT:    out_next.read_data = ch_count[sel.ch];
                crdt_pkg::SEL_CTRL:     out_next.read_data = {16'd0, ch_control[sel.ch]};
                default:                out_next.read_data = 32'd0;
            endcase
        end
    end

    // Input register: hold until processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // Shared registers and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            outctl_reg  <= '0;
            capture_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            start_reg   <= start_next;
            outctl_reg  <= outctl_next;
            capture_reg <= capture_next;
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // A processed item always leaves a result behind
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_vld_reg)
        else $error("processed item produced no result");

    // Ticks and writes return zero read data
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_reg.kind != crdt_pkg::KIND_READ) |=> (out_reg.read_data == 32'd0))
        else $error("non-read item returned nonzero read data");

    // A held item is neither lost nor overwritten while the result stalls
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !fire) |=> (in_vld_reg && $stable(in_reg)))
        else $error("pending item lost during stall");

    // Absent channels never raise a request
    a_absent_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_reg.irq_lines >> CHANNELS) == 3'd0))
        else $error("request raised on an absent channel");

endmodule

// ===== sim/crdt_timer_checker.sv =====
// Checker for the three-channel reload down timer: watches both channels, keeps its
// own copy of the timer registers, predicts each result and compares it on transfer.
// Depends on crdt_pkg.
module crdt_timer_checker #(
    parameter int CHANNELS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  crdt_pkg::crdt_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  crdt_pkg::crdt_out_t out_data,
    output int                  outstanding,
    output int                  mismatches
);

    localparam logic [10:0] TICKS_PER_STEP [8] = '{
        11'd4, 11'd16, 11'd64, 11'd256, 11'd1024, 11'd1, 11'd1, 11'd1
    };

    // Shadow copy of the timer registers
    logic [31:0] count_q    [3];
    logic [31:0] reload_q   [3];
    logic [15:0] ctrl_q     [3];
    logic [9:0]  presc_q    [3];
    logic        irq_q      [3];
    logic [7:0]  run_q;
    logic [7:0]  out_ctrl_q;
    logic [31:0] capture_q;

    crdt_pkg::crdt_out_t expected_results [$];
    int                  fail_total = 0;

    function automatic logic [31:0] byte_lanes(input logic [3:0] be);
        logic [31:0] m;
        for (int lane = 0; lane < 4; lane++) begin
            m[lane*8 +: 8] = be[lane] ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    task automatic clear_registers();
        for (int c = 0; c < 3; c++) begin
            count_q[c]  = '1;
            reload_q[c] = '1;
            ctrl_q[c]   = '0;
            presc_q[c]  = '0;
            irq_q[c]    = 1'b0;
        end
        run_q      = '0;
        out_ctrl_q = '0;
        capture_q  = '0;
    endtask

    // Advance one running channel by one peripheral tick
    task automatic tick_channel(input int c);
        logic [10:0] period;
        logic [10:0] nxt;
        period = TICKS_PER_STEP[ctrl_q[c][2:0]];
        nxt    = {1'b0, presc_q[c]} + 11'd1;
        if (nxt < period) begin
            presc_q[c] = nxt[9:0];
        end
        else begin
            presc_q[c] = '0;
            if (count_q[c] == 32'd0) begin
                count_q[c] = reload_q[c];
                ctrl_q[c]  = ctrl_q[c] | crdt_pkg::FLAG_UNDERFLOW;
                if ((ctrl_q[c] & crdt_pkg::FLAG_IRQ_ENABLE) != '0)
                    irq_q[c] = 1'b1;
            end
            else begin
                count_q[c] = count_q[c] - 32'd1;
            end
        end
    endtask

    // Apply one item to the shadow registers and form its result
    task automatic apply_item(input crdt_pkg::crdt_in_t item, output crdt_pkg::crdt_out_t res);
        logic [31:0] lanes;
        logic [31:0] wd;
        int          ch;
        bit          chan_reg;
        res      = '0;
        lanes    = byte_lanes(item.byte_enable);
        wd       = item.write_data & lanes;
        chan_reg = (item.reg_index >= crdt_pkg::REG_CONST0) &&
                   (item.reg_index <= crdt_pkg::REG_CTRL2);
        ch       = chan_reg ? (int'(item.reg_index) - int'(crdt_pkg::REG_CONST0)) / 3 : 0;
        if (chan_reg && ch >= CHANNELS)
            chan_reg = 0;
        if (item.kind == crdt_pkg::KIND_TICK) begin
            for (int c = 0; c < 3; c++) begin
                if (c < CHANNELS && run_q[c])
                    tick_channel(c);
            end
        end
        else if (item.kind == crdt_pkg::KIND_READ) begin
            case (item.reg_index)
                crdt_pkg::REG_OUT_CTRL: res.read_data = {24'd0, out_ctrl_q};
                crdt_pkg::REG_START:    res.read_data = {24'd0, run_q};
                crdt_pkg::REG_CAPTURE:  res.read_data = capture_q;
                crdt_pkg::REG_CONST0, crdt_pkg::REG_CONST1, crdt_pkg::REG_CONST2:
                    if (chan_reg) res.read_data = reload_q[ch];
                crdt_pkg::REG_COUNT0, crdt_pkg::REG_COUNT1, crdt_pkg::REG_COUNT2:
                    if (chan_reg) res.read_data = count_q[ch];
                crdt_pkg::REG_CTRL0, crdt_pkg::REG_CTRL1, crdt_pkg::REG_CTRL2:
                    if (chan_reg) res.read_data = {16'd0, ctrl_q[ch]};
                default: ;
            endcase
        end
        else if (item.kind == crdt_pkg::KIND_WRITE) begin
            case (item.reg_index)
                crdt_pkg::REG_OUT_CTRL: out_ctrl_q = (out_ctrl_q & ~lanes[7:0]) | wd[7:0];
                crdt_pkg::REG_START: begin
                    run_q = (run_q & ~lanes[7:0]) | wd[7:0];
                    for (int c = 0; c < 3; c++)
                        presc_q[c] = '0;
                end
                crdt_pkg::REG_CAPTURE: capture_q = (capture_q & ~lanes) | wd;
                crdt_pkg::REG_CONST0, crdt_pkg::REG_CONST1, crdt_pkg::REG_CONST2:
                    if (chan_reg) reload_q[ch] = (reload_q[ch] & ~lanes) | wd;
                crdt_pkg::REG_COUNT0, crdt_pkg::REG_COUNT1, crdt_pkg::REG_COUNT2:
                    if (chan_reg) count_q[ch] = (count_q[ch] & ~lanes) | wd;
                crdt_pkg::REG_CTRL0, crdt_pkg::REG_CTRL1, crdt_pkg::REG_CTRL2:
                    if (chan_reg) begin
                        ctrl_q[ch] = (ctrl_q[ch] & ~lanes[15:0]) | wd[15:0];
                        // drop the request unless both enable and flag survive
                        if ((ctrl_q[ch] & crdt_pkg::FLAG_IRQ_ENABLE) == '0 ||
                            (ctrl_q[ch] & crdt_pkg::FLAG_UNDERFLOW) == '0)
                            irq_q[ch] = 1'b0;
                    end
                default: ;
            endcase
            if (chan_reg)
                presc_q[ch] = '0;
        end
        res.irq_lines = {irq_q[2], irq_q[1], irq_q[0]};
    endtask

    // Compare each result transfer, then record the prediction for each item transfer
    always @(posedge clk or negedge rst_n) begin
        crdt_pkg::crdt_out_t predicted;
        crdt_pkg::crdt_out_t oldest;
        if (!rst_n) begin
            clear_registers();
            expected_results.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result read_data %h irq_lines %b",
                             $time, out_data.read_data, out_data.irq_lines);
                    fail_total++;
                end
                else begin
                    oldest = expected_results.pop_front();
                    if (out_data.read_data !== oldest.read_data) begin
                        $display("%0t: read_data expected %h, got %h",
                                 $time, oldest.read_data, out_data.read_data);
                        fail_total++;
                    end
                    if (out_data.irq_lines !== oldest.irq_lines) begin
                        $display("%0t: irq_lines expected %b, got %b",
                                 $time, oldest.irq_lines, out_data.irq_lines);
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                apply_item(in_data, predicted);
                expected_results.push_back(predicted);
            end
            outstanding <= expected_results.size();
            mismatches  <= fail_total;
        end
    end

endmodule

// ===== sim/tb_three_channel_reload_down_timer.sv =====
// Testbench top for the three-channel reload down timer: clock, reset, stimulus,
// handshake idling, watchdog and verdict. Depends on crdt_pkg, the timer RTL and
// crdt_timer_checker.
module tb_three_channel_reload_down_timer;

    localparam int         RANDOM_ITEMS = 1950;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 4;
    localparam logic [1:0] KIND_NONE    = 2'd3;
    localparam logic [3:0] REG_UNMAPPED_LO = 4'd12;
    localparam logic [3:0] REG_UNMAPPED_HI = 4'd15;
    localparam logic [2:0] CLK_DIV4     = 3'd0;
    localparam logic [2:0] CLK_DIV16    = 3'd1;
    localparam logic [2:0] CLK_DIV64    = 3'd2;
    localparam logic [2:0] CLK_DIV256   = 3'd3;
    localparam logic [2:0] CLK_DIV1024  = 3'd4;
    localparam logic [2:0] CLK_DIV1     = 3'd5;
    localparam logic [2:0] CLK_DIV1_ALT = 3'd7;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    crdt_pkg::crdt_in_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    crdt_pkg::crdt_out_t out_data;
    int                  outstanding;
    int                  mismatches;
    int                  send_idle_pct = 22;
    int                  recv_idle_pct = 55;
    int                  quiet_cycles  = 0;

    always #5 clk = ~clk;

    three_channel_reload_down_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    crdt_timer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // Stall the result side at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic crdt_pkg::crdt_in_t make_item(input logic [1:0] kind,
                                                     input logic [3:0] idx,
                                                     input logic [31:0] data,
                                                     input logic [3:0] be);
        crdt_pkg::crdt_in_t item;
        item.kind        = kind;
        item.reg_index   = idx;
        item.write_data  = data;
        item.byte_enable = be;
        return item;
    endfunction

    // Hold one item on the input channel until it transfers
    task automatic send_item(input crdt_pkg::crdt_in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [2:0] pick_clock_sel();
        int p;
        p = $urandom_range(99);
        if (p < 40)      return p[0] ? CLK_DIV1 : CLK_DIV1_ALT - 3'($urandom_range(1));
        else if (p < 75) return CLK_DIV4;
        else if (p < 90) return CLK_DIV16;
        else if (p < 97) return CLK_DIV64;
        else             return p[0] ? CLK_DIV256 : CLK_DIV1024;
    endfunction

    // Random item, weighted toward ticks and toward register writes that make channels underflow
    function automatic crdt_pkg::crdt_in_t random_item();
        crdt_pkg::crdt_in_t item;
        int                 k;
        int                 r;
        item.kind        = crdt_pkg::KIND_TICK;
        item.reg_index   = 4'($urandom_range(15));
        item.write_data  = $urandom();
        item.byte_enable = ($urandom_range(3) != 0) ? 4'hF : 4'($urandom_range(15));
        k = $urandom_range(99);
        r = $urandom_range(99);
        if (k < 58) begin
            item.kind = crdt_pkg::KIND_TICK;
        end
        else if (k < 72) begin
            item.kind = crdt_pkg::KIND_READ;
        end
        else if (k < 98) begin
            item.kind = crdt_pkg::KIND_WRITE;
            if (r < 30) begin
                item.reg_index = crdt_pkg::REG_CTRL0 + 4'(3 * $urandom_range(2));
                item.write_data[2:0] = pick_clock_sel();
            end
            else if (r < 62) begin
                item.reg_index = (r < 50) ?
                                 crdt_pkg::REG_COUNT0 + 4'(3 * $urandom_range(2)) :
                                 crdt_pkg::REG_CONST0 + 4'(3 * $urandom_range(2));
                if ($urandom_range(9) < 7)
                    item.write_data = $urandom_range(6);
            end
            else if (r < 72) begin
                item.reg_index = crdt_pkg::REG_START;
                if ($urandom_range(9) < 7)
                    item.write_data[2:0] = 3'b111;
            end
        end
        else begin
            item.kind = KIND_NONE;
        end
        return item;
    endfunction

    initial begin
        crdt_pkg::crdt_in_t item;
        int                 counted;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, underflow and interrupt, masking, odd registers
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_COUNT0, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_COUNT0, 32'h0, 4'hF));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_CONST0, 32'h2, 4'hF));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_CTRL0,
                            32'(crdt_pkg::FLAG_IRQ_ENABLE) | 32'(CLK_DIV1), 4'hF));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_START, 32'h1, 4'h1));
        send_item(make_item(crdt_pkg::KIND_TICK,  crdt_pkg::REG_CTRL0, 32'hFFFF_FFFF, 4'hF));
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_CTRL0, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_CTRL0, 32'(CLK_DIV1), 4'h1));
        repeat (3) send_item(make_item(crdt_pkg::KIND_TICK, crdt_pkg::REG_OUT_CTRL,
                                       32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_CTRL2, 32'hFFFF_FFFF, 4'hF));
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_CTRL2, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_COUNT1, 32'h0000_AB00, 4'h2));
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_COUNT1, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_START, 32'hFFFF_FFFF, 4'hF));
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_START, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_TICK,  crdt_pkg::REG_START, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_CAPTURE, 32'hDEAD_BEEF, 4'hA));
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_CAPTURE, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_OUT_CTRL, 32'h0000_01FF, 4'h3));
        send_item(make_item(crdt_pkg::KIND_READ,  crdt_pkg::REG_OUT_CTRL, 32'h0, 4'h0));
        send_item(make_item(crdt_pkg::KIND_WRITE, REG_UNMAPPED_LO, 32'hFFFF_FFFF, 4'hF));
        send_item(make_item(crdt_pkg::KIND_READ,  REG_UNMAPPED_HI, 32'h0, 4'h0));
        send_item(make_item(KIND_NONE,            crdt_pkg::REG_COUNT0, 32'hFFFF_FFFF, 4'hF));
        send_item(make_item(crdt_pkg::KIND_WRITE, crdt_pkg::REG_START, 32'h0, 4'h1));
        send_item(make_item(crdt_pkg::KIND_TICK,  crdt_pkg::REG_COUNT0, 32'h0, 4'h0));

        // Random: three idling profiles, ignored items not counted
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 22 : 0;
            counted = 0;
            while (counted < RANDOM_ITEMS / 3) begin
                item = random_item();
                send_item(item);
                if (item.kind != KIND_NONE &&
                    !(item.kind == crdt_pkg::KIND_WRITE && item.reg_index >= REG_UNMAPPED_LO))
                    counted++;
            end
        end

        // Drain the remaining results
        in_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
